FILE: rtl/core/regret_matching_normalizer_top_defines.svh
`ifndef REGRET_MATCHING_NORMALIZER_TOP_DEFINES_SVH
`define REGRET_MATCHING_NORMALIZER_TOP_DEFINES_SVH

// same-cycle implication on clock, held off during reset
`define RMN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on clock, held off during reset
`define RMN_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/rmn_pkg.sv
`timescale 1ns / 1ps

package rmn_pkg;

   localparam int MAX_ACTIONS = 16;

   localparam int VALUE_W = 32;
   localparam int PROB_W  = 17;
   localparam int INDEX_W = 6;

   localparam int CNT_W  = $clog2(MAX_ACTIONS + 1);
   localparam int ADDR_W = $clog2(MAX_ACTIONS);
   localparam int SUM_W  = VALUE_W + ADDR_W;
   localparam int DVR_W  = SUM_W - 1;
   localparam int DVD_W  = VALUE_W - 1;
   localparam int QUO_W  = PROB_W;
   localparam int STEP_W = $clog2(QUO_W + 1);

   localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

   typedef struct packed {
      logic              load;
      logic              clear;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } buf_ctrl_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
      logic                    dropped;
   } buf_sts_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
      logic             overflow;
   } div_res_type;

endpackage

FILE: rtl/core/regret_matching_normalizer_top.sv
// loading: one request per cycle, the request with last set closes the vector
// then one result per stored action, each from:
// a buffer read, 18 steps of the shared restoring divider (one step when the quotient overflows) and emit
// requests are stalled from the closing request until the last result is registered
// synchronous active-high reset clears control state; the buffer's clamp flag resets to 1
`timescale 1ns / 1ps
`include "regret_matching_normalizer_top_defines.svh"

module regret_matching_normalizer_top import rmn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [PROB_W-1:0]         rsp_probability,
   output logic [INDEX_W-1:0]        rsp_action_index,
   output logic                      rsp_last_out,
   output logic                      rsp_clipped,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data
);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]                state_ff;
   logic [2:0]                state_in;
   logic [ADDR_W-1:0]         idx_ff;
   logic [ADDR_W-1:0]         idx_in;
   logic                      xneg_ff;
   logic                      xneg_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [PROB_W-1:0]         rsp_prob_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic                      rsp_last_ff;
   logic                      rsp_clip_ff;

   buf_ctrl_type              buf_ctrl;
   buf_sts_type               buf_sts;
   div_req_type               div_req;
   div_res_type               div_res;
   logic signed [VALUE_W-1:0] rd_data;

   logic                      req_acc;
   logic                      rsp_free;
   logic                      sum_pos;
   logic                      is_last_idx;
   logic                      emit_fire;
   logic [PROB_W-1:0]         prob;
   logic                      clip;

   rmn_vector_buf u_buf (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctrl        (buf_ctrl),
      .value       (req_value),
      .sts         (buf_sts),
      .rd_data     (rd_data)
   );

   rmn_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   assign req_stall   = (state_ff != ST_LOAD);
   assign req_acc     = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign sum_pos     = !buf_sts.sum[SUM_W-1] && (|buf_sts.sum);
   assign is_last_idx = (CNT_W'(idx_ff) + CNT_W'(1)) == buf_sts.count;
   assign emit_fire   = (state_ff == ST_EMIT) && rsp_free;

   assign buf_ctrl.load    = req_acc;
   assign buf_ctrl.clear   = emit_fire && is_last_idx;
   assign buf_ctrl.rd_en   = (state_ff == ST_READ);
   assign buf_ctrl.rd_addr = idx_ff;

   // the divider scales the dividend by one, so one over n gives the uniform share
   assign div_req.start    = (state_ff == ST_START);
   assign div_req.dividend = sum_pos ? rd_data[DVD_W-1:0] : DVD_W'(1);
   assign div_req.divisor  = sum_pos ? buf_sts.sum[DVR_W-1:0] : DVR_W'(buf_sts.count);

   // saturation and flags
   always_comb begin
      if (sum_pos && xneg_ff) begin
         prob = '0;
         clip = 1'b1;
      end else if (sum_pos && (div_res.overflow || div_res.quotient > ONE_Q16)) begin
         prob = ONE_Q16;
         clip = 1'b1;
      end else begin
         prob = div_res.quotient;
         clip = buf_sts.dropped;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      xneg_in  = xneg_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc && req_last) begin
               state_in = ST_READ;
               idx_in   = '0;
            end
         end
         ST_READ: begin
            state_in = ST_START;
         end
         ST_START: begin
            xneg_in  = rd_data[VALUE_W-1];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               if (is_last_idx) begin
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xneg_ff <= xneg_in;
      if (emit_fire) begin
         rsp_prob_ff  <= prob;
         rsp_index_ff <= INDEX_W'(idx_ff);
         rsp_last_ff  <= is_last_idx;
         rsp_clip_ff  <= clip;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_probability  = rsp_prob_ff;
   assign rsp_action_index = rsp_index_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_clipped      = rsp_clip_ff;

   `RMN_ASSERT_IMP(a_div_done_in_div, div_res.done, state_ff == ST_DIV, "done outside division")
   `RMN_ASSERT_NXT(a_close_clears, buf_ctrl.clear, (state_ff == ST_LOAD) && (buf_sts.count == '0), "not cleared")
   `RMN_ASSERT_IMP(a_prob_range, rsp_valid, rsp_probability <= ONE_Q16, "probability above one")

endmodule

FILE: rtl/core/rmn_vector_buf.sv
`timescale 1ns / 1ps

module rmn_vector_buf import rmn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  buf_ctrl_type              ctrl,
   input  logic signed [VALUE_W-1:0] value,
   output buf_sts_type               sts,
   output logic signed [VALUE_W-1:0] rd_data
);

   logic                      clamp_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      dropped_ff;
   logic                      dropped_in;
   logic signed [VALUE_W-1:0] store_ff [MAX_ACTIONS];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic signed [VALUE_W-1:0] stored;
   logic                      has_room;

   assign stored   = (clamp_ff && value[VALUE_W-1]) ? '0 : value;
   assign has_room = count_ff < CNT_W'(MAX_ACTIONS);

   always_comb begin
      sum_in     = sum_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (ctrl.clear) begin
         sum_in     = '0;
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (ctrl.load) begin
         if (has_room) begin
            sum_in   = sum_ff + {{(SUM_W - VALUE_W){stored[VALUE_W-1]}}, stored};
            count_in = count_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff   <= 1'b1;
         sum_ff     <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            clamp_ff <= csr_wr_data;
         end
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load && has_room) begin
         store_ff[count_ff[ADDR_W-1:0]] <= stored;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= store_ff[ctrl.rd_addr];
      end
   end

   assign sts.sum     = sum_ff;
   assign sts.count   = count_ff;
   assign sts.dropped = dropped_ff;
   assign rd_data     = rd_data_ff;

endmodule

FILE: rtl/core/rmn_divider.sv
`timescale 1ns / 1ps

module rmn_divider import rmn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_res_type res
);

   localparam logic [STEP_W-1:0] STEP_OVF = STEP_W'(QUO_W);
   localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(QUO_W - 1);

   logic              busy_ff;
   logic              busy_in;
   logic              done_ff;
   logic              done_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [SUM_W-1:0]  rem_ff;
   logic [SUM_W-1:0]  rem_in;
   logic [DVR_W-1:0]  dvr_ff;
   logic [DVR_W-1:0]  dvr_in;
   logic [QUO_W-1:0]  quo_ff;
   logic [QUO_W-1:0]  quo_in;
   logic              ovf_ff;
   logic              ovf_in;
   logic [SUM_W-1:0]  op_a;
   logic [SUM_W-1:0]  op_b;
   logic [SUM_W:0]    diff;
   logic              ge;

   // shared compare-subtract
   always_comb begin
      if (step_ff == STEP_OVF || step_ff == STEP_TOP) begin
         op_a = rem_ff;
      end else begin
         op_a = {rem_ff[SUM_W-2:0], 1'b0};
      end
      if (step_ff == STEP_OVF) begin
         op_b = {dvr_ff, 1'b0};
      end else begin
         op_b = {1'b0, dvr_ff};
      end
      diff = {1'b0, op_a} - {1'b0, op_b};
      ge   = ~diff[SUM_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvr_in  = dvr_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = STEP_OVF;
         rem_in  = SUM_W'(req.dividend);
         dvr_in  = req.divisor;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         if (step_ff == STEP_OVF) begin
            if (ge) begin
               ovf_in  = 1'b1;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end else begin
            rem_in = ge ? diff[SUM_W-1:0] : op_a;
            quo_in = {quo_ff[QUO_W-2:0], ge};
            if (step_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvr_ff <= dvr_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;
   assign res.overflow = ovf_ff;

endmodule

FILE: tb/sv/regret_matching_normalizer_top_test.sv
`timescale 1ns / 1ps

module regret_matching_normalizer_top_test;
   import rmn_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value;
   logic                      req_last;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [PROB_W-1:0]         rsp_probability;
   logic [INDEX_W-1:0]        rsp_action_index;
   logic                      rsp_last_out;
   logic                      rsp_clipped;
   logic                      csr_wr_en;
   logic                      csr_wr_data;

   regret_matching_normalizer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_probability  (rsp_probability),
      .rsp_action_index (rsp_action_index),
      .rsp_last_out     (rsp_last_out),
      .rsp_clipped      (rsp_clipped),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   typedef struct {
      logic [PROB_W-1:0]  probability;
      logic [INDEX_W-1:0] action_index;
      logic               last_out;
      logic               clipped;
   } prob_result_type;

   typedef struct {
      int value;
      int reps;
      bit last;
      bit clamp;
      bit pinned;
      int prob;
      bit clip;
   } vector_row_type;

   // normalizer state as seen by the checker
   int     weights [MAX_ACTIONS];
   longint weight_sum;
   int     weight_count;
   bit     weights_dropped;
   bit     clamp_mode;

   prob_result_type expected_probs[$];
   vector_row_type  vector_rows [15];

   int errors;
   int requests_sent;
   int vectors_closed;
   int overflow_vectors;
   int results_seen;
   int burst_left;
   int random_items;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic model_request(input int value, input bit last, input bit pinned,
                                input int pin_prob, input bit pin_clip);
      int              v;
      longint          x;
      longint          q;
      prob_result_type r;
      v = value;
      if (clamp_mode && v < 0) v = 0;
      if (weight_count < MAX_ACTIONS) begin
         weights[weight_count] = v;
         weight_sum += v;
         weight_count++;
      end else begin
         weights_dropped = 1'b1;
      end
      if (last) begin
         for (int k = 0; k < weight_count; k++) begin
            x = weights[k];
            r.clipped = weights_dropped;
            if (weight_sum > 0) begin
               if (x < 0) begin
                  r.probability = '0;
                  r.clipped = 1'b1;
               end else begin
                  q = (x * 65536) / weight_sum;
                  if (q > longint'(ONE_Q16)) begin
                     r.probability = ONE_Q16;
                     r.clipped = 1'b1;
                  end else begin
                     r.probability = PROB_W'(q);
                  end
               end
            end else begin
               r.probability = PROB_W'(65536 / weight_count);
            end
            r.action_index = INDEX_W'(k);
            r.last_out = (k == weight_count - 1);
            if (pinned) begin
               r.probability = PROB_W'(pin_prob);
               r.clipped = pin_clip;
            end
            expected_probs.push_back(r);
         end
         vectors_closed++;
         if (weights_dropped) overflow_vectors++;
         weight_sum = 0;
         weight_count = 0;
         weights_dropped = 1'b0;
      end
   endtask

   task automatic send_request(input int value, input bit last, input bit pinned,
                               input int pin_prob, input bit pin_clip);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
                                                     $urandom_range(1, 6);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last  <= last;
      do @(posedge clock); while (req_stall);
      burst_left--;
      requests_sent++;
      model_request(value, last, pinned, pin_prob, pin_clip);
   endtask

   task automatic set_clamp_when_idle(input bit clamp);
      req_valid <= 1'b0;
      while (expected_probs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= clamp;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      clamp_mode = clamp;
   endtask

   function automatic int pick_value();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return $urandom;
         4, 5, 6: return $urandom_range(0, 32'h0010_0000);
         7: return -int'($urandom_range(1, 32'h0010_0000));
         8: return $urandom_range(0, 32'h0000_FFFF) << 15;
         default: return $urandom_range(0, 32'h7FFF_FFFF);
      endcase
   endfunction

   // receiver stall stretches
   initial begin
      int mode;
      int len;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         len = $urandom_range(10, 150);
         for (int c = 0; c < len; c++) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((c % 7) >= 4);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      prob_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_probs.size() == 0) begin
            $error("unexpected result index %0d probability %0d", rsp_action_index,
                   rsp_probability);
            errors++;
         end else begin
            e = expected_probs.pop_front();
            if (rsp_probability !== e.probability) begin
               $error("probability expected %0d got %0d", e.probability, rsp_probability);
               errors++;
            end
            if (rsp_action_index !== e.action_index) begin
               $error("action_index expected %0d got %0d", e.action_index,
                      rsp_action_index);
               errors++;
            end
            if (rsp_last_out !== e.last_out) begin
               $error("last_out expected %0d got %0d", e.last_out, rsp_last_out);
               errors++;
            end
            if (rsp_clipped !== e.clipped) begin
               $error("clipped expected %0d got %0d", e.clipped, rsp_clipped);
               errors++;
            end
         end
      end
   end

   initial begin
      int len;
      bit next_clamp;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_value   = '0;
      req_last    = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      errors = 0;
      requests_sent = 0;
      vectors_closed = 0;
      overflow_vectors = 0;
      results_seen = 0;
      burst_left = 0;
      random_items = 0;
      weight_sum = 0;
      weight_count = 0;
      weights_dropped = 1'b0;
      clamp_mode = 1'b1;

      vector_rows = '{
         '{32'h0001_0000, 1, 1, 1, 1, 65536, 0},
         '{32'h8000_0000, 1, 1, 1, 1, 65536, 0},
         '{32'h7FFF_FFFF, 1, 0, 1, 0, 0, 0},
         '{32'h7FFF_FFFF, 1, 1, 1, 1, 32768, 0},
         '{-1, 1, 0, 1, 0, 0, 0},
         '{0, 1, 1, 1, 1, 32768, 0},
         '{0, 17, 1, 1, 1, 4096, 1},
         '{-65536, 1, 0, 0, 0, 0, 0},
         '{196608, 1, 1, 0, 0, 0, 0},
         '{32'h8000_0000, 1, 1, 0, 1, 65536, 0},
         '{1, 1, 0, 0, 0, 0, 0},
         '{2, 1, 1, 0, 0, 0, 0},
         '{-1, 1, 0, 0, 0, 0, 0},
         '{1, 1, 1, 0, 1, 32768, 0},
         '{32'h7FFF_FFFF, 1, 1, 0, 1, 65536, 0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vector_rows[i]) begin
         if (vector_rows[i].clamp != clamp_mode) set_clamp_when_idle(vector_rows[i].clamp);
         for (int r = 0; r < vector_rows[i].reps; r++)
            send_request(vector_rows[i].value,
                         vector_rows[i].last && (r == vector_rows[i].reps - 1),
                         vector_rows[i].pinned, vector_rows[i].prob, vector_rows[i].clip);
      end

      // random phases, clamp mode flips between them
      next_clamp = 1'b1;
      while (random_items < 170) begin
         set_clamp_when_idle(next_clamp);
         next_clamp = ~next_clamp;
         repeat ($urandom_range(2, 5)) begin
            case ($urandom_range(0, 9))
               0: len = $urandom_range(17, 20);
               1, 2: len = $urandom_range(7, 16);
               default: len = $urandom_range(1, 6);
            endcase
            for (int j = 0; j < len; j++) begin
               send_request(pick_value(), j == len - 1, 1'b0, 0, 1'b0);
               random_items++;
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_probs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d requests closing %0d vectors (%0d overflowing), checked %0d results",
               requests_sent, vectors_closed, overflow_vectors, results_seen);
      $display("both clamp settings used, zero and negative sums and saturation included");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
